[rtl/core/arp_cache_responder_defines.svh]
// assertion macros for the arp cache responder
`ifndef ARP_CACHE_RESPONDER_DEFINES_SVH
`define ARP_CACHE_RESPONDER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define ARPC_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("arp cache responder check failed");

// condition that implies a consequence in the next cycle
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("arp cache responder check failed");

`endif

[rtl/core/arpc_pkg.sv]
// shared types and constants of the arp cache responder
`default_nettype none

package arpc_pkg;

	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int OPC_W   = 16;
	localparam int ENTRY_W = IP_W + MAC_W;
	localparam int CFG_IDX_W = 8;

	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_ADD    = 2'd2;

	localparam logic [OPC_W-1:0] ARP_OP_REQUEST = 16'd1;

	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP = 8'd0;

	localparam logic [IP_W-1:0] LOCAL_IP_RESET = 32'h0A00020E;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} arpc_state_t;

	typedef struct packed {
		logic [MAC_W-1:0] found_mac;
		logic             lookup_hit;
		logic [IP_W-1:0]  reply_dest_ip;
		logic [MAC_W-1:0] reply_dest_mac;
		logic             reply_valid;
	} arpc_result_t;

endpackage

`default_nettype wire

[rtl/core/arpc_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/arp_cache_responder.sv]
// packet, add and unused-op words: result registered in res_q as the word is taken, then
// moved to the output register when free; lookup: scan from index 0 to a hit or the last
// filled entry (empty table: no scan); one table entry read per cycle from one ram port
// next word taken in the cycle after the result loads the output register, not before
// reset clears the fill count, write pointer, fsm and output valid, and sets local_ip
// to 10.0.2.14; the ram is not cleared, entries at or above the fill count never match
`default_nettype none

module arp_cache_responder
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 512
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// arp_opcode, src_mac, ip_addr, target_ip
	input  wire logic [127:0]         s_tdata,
	// op
	input  wire logic [1:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// reply_dest_mac, reply_dest_ip, found_mac
	output logic      [127:0]         m_tdata,
	// reply_valid, lookup_hit
	output logic      [1:0]           m_tuser,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [MAC_W-1:0]     cfg_data
);

	`include "arp_cache_responder_defines.svh"

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	arpc_state_t state_q, state_d;

	logic [IP_W-1:0]  local_ip_q;
	logic [IW-1:0]    wr_idx_q;
	logic [CW-1:0]    fill_q;
	logic [IW-1:0]    rd_addr_s1;
	logic [IP_W-1:0]  key_ip_q;
	arpc_result_t     res_q, res_d;
	arpc_result_t     out_q;
	logic             m_tvalid_q;

	logic [1:0]       in_op;
	logic [OPC_W-1:0] in_opcode;
	logic [MAC_W-1:0] in_mac;
	logic [IP_W-1:0]  in_ip;
	logic [IP_W-1:0]  in_tip;

	logic             in_acc;
	logic             wr_en;
	logic             rd_en;
	logic [IW-1:0]    rd_addr;
	logic             load_res;
	logic             load_out;
	logic             scan_step;
	logic             store_step;
	logic [ENTRY_W-1:0] rd_data;
	logic [IP_W-1:0]  rd_ip;
	logic [MAC_W-1:0] rd_mac;
	logic [CW-1:0]    last_idx;

	assign in_opcode = s_tdata[15:0];
	assign in_mac    = s_tdata[63:16];
	assign in_ip     = s_tdata[95:64];
	assign in_tip    = s_tdata[127:96];
	assign in_op     = s_tuser;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign rd_ip    = rd_data[IP_W-1:0];
	assign rd_mac   = rd_data[ENTRY_W-1:IP_W];
	assign last_idx = fill_q - CW'(1);

	arpc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx_q),
		.wdata({in_mac, in_ip}),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		res_d      = '0;
		load_res   = 1'b0;
		load_out   = 1'b0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		scan_step  = 1'b0;
		store_step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					load_res = 1'b1;
					state_d  = ST_EMIT;
					case (in_op)
						OP_PACKET: begin
							wr_en      = 1'b1;
							store_step = 1'b1;
							if (in_opcode == ARP_OP_REQUEST && in_tip == local_ip_q) begin
								res_d.reply_valid    = 1'b1;
								res_d.reply_dest_mac = in_mac;
								res_d.reply_dest_ip  = in_ip;
							end
						end
						OP_ADD: begin
							wr_en      = 1'b1;
							store_step = 1'b1;
						end
						OP_LOOKUP: begin
							if (fill_q != '0) begin
								rd_en   = 1'b1;
								state_d = ST_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (rd_ip == key_ip_q) begin
					load_res         = 1'b1;
					res_d.lookup_hit = 1'b1;
					res_d.found_mac  = rd_mac;
					state_d          = ST_EMIT;
				end else if (CW'(rd_addr_s1) == last_idx) begin
					load_res = 1'b1;
					state_d  = ST_EMIT;
				end else begin
					rd_en     = 1'b1;
					rd_addr   = rd_addr_s1 + IW'(1);
					scan_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= LOCAL_IP_RESET;
			wr_idx_q   <= '0;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// local_mac has no output path, so a write to it is taken and dropped
			if (cfg_valid && cfg_ready && cfg_index == REG_LOCAL_IP) begin
				local_ip_q <= cfg_data[IP_W-1:0];
			end
			if (store_step) begin
				if (wr_idx_q == IW'(TABLE_ENTRIES - 1)) begin
					wr_idx_q <= '0;
				end else begin
					wr_idx_q <= wr_idx_q + IW'(1);
				end
				if (fill_q != CW'(TABLE_ENTRIES)) begin
					fill_q <= fill_q + CW'(1);
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_ip_q   <= in_ip;
			rd_addr_s1 <= '0;
		end else if (scan_step) begin
			rd_addr_s1 <= rd_addr;
		end
		if (load_res) begin
			res_q <= res_d;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.found_mac, out_q.reply_dest_ip, out_q.reply_dest_mac};
	assign m_tuser  = {out_q.lookup_hit, out_q.reply_valid};

	`ARPC_ASSERT(a_fill_bound, fill_q <= CW'(TABLE_ENTRIES))
	`ARPC_ASSERT(a_ring_in_order, fill_q == CW'(TABLE_ENTRIES) || CW'(wr_idx_q) == fill_q)
	`ARPC_ASSERT(a_scan_in_table, state_q != ST_SCAN || CW'(rd_addr_s1) < fill_q)
	`ARPC_ASSERT_NEXT(a_lookup_starts, in_acc && in_op == OP_LOOKUP && fill_q != '0,
		state_q == ST_SCAN && rd_addr_s1 == '0)
	`ARPC_ASSERT_NEXT(a_emit_loads, state_q == ST_EMIT && (!m_tvalid_q || m_tready),
		m_tvalid_q && state_q == ST_IDLE)

endmodule

`default_nettype wire
